// ===== hdl/oxygen_cell_vote_defines.svh =====
// assertion macros used by the checker file
`ifndef OXYGEN_CELL_VOTE_DEFINES_SVH
`define OXYGEN_CELL_VOTE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define OCV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define OCV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ocv_pkg.sv =====
`timescale 1ns / 1ps

package ocv_pkg;

	localparam int PPO2_W = 8;
	localparam int MV_W   = 16;
	localparam int CELL_N = 3;
	localparam int CFG_W  = 8;
	localparam int SUM_W  = PPO2_W + 2;
	localparam int CNT_W  = 2;

	// floor(x / 3) == (x * 683) >> 11 for every x below 2048
	localparam int DIV3_SHIFT = 11;
	localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = DIV3_SHIFT'(683);

	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

	localparam logic [CELL_N-1:0] CELL1_BIT = 3'h1;
	localparam logic [CELL_N-1:0] CELL2_BIT = 3'h2;
	localparam logic [CELL_N-1:0] CELL3_BIT = 3'h4;

	localparam logic [CFG_W-1:0] DEV_LIMIT_RST  = 8'd15;
	localparam logic [CFG_W-1:0] FAIL_VALUE_RST = 8'd255;

	typedef enum logic {
		REG_DEV_LIMIT  = 1'b0,
		REG_FAIL_VALUE = 1'b1
	} cfg_reg_t;

	typedef logic [PPO2_W-1:0] ppo2_t;
	typedef logic [MV_W-1:0]   mv_t;
	typedef logic [CELL_N-1:0] cell_mask_t;

	typedef struct packed {
		ppo2_t      cell1_ppo2;
		ppo2_t      cell2_ppo2;
		ppo2_t      cell3_ppo2;
		mv_t        cell1_mv;
		mv_t        cell2_mv;
		mv_t        cell3_mv;
		cell_mask_t need_cal_flags;
	} ocv_in_t;

	typedef struct packed {
		ppo2_t      out_cell1_ppo2;
		ppo2_t      out_cell2_ppo2;
		ppo2_t      out_cell3_ppo2;
		mv_t        out_cell1_mv;
		mv_t        out_cell2_mv;
		mv_t        out_cell3_mv;
		ppo2_t      consensus_ppo2;
		cell_mask_t voted_out_mask;
	} ocv_out_t;

endpackage

// ===== hdl/ocv_stream_if.sv =====
`timescale 1ns / 1ps

interface ocv_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/oxygen_cell_vote.sv =====
// an accepted sample word passes the s1, s2 and s3 registers on its way to its result word on vote
// throughput: one word per cycle while vote is ready, set by the three-stage compare/sum/divide pipeline
// a stall on vote holds the stages back one by one; nothing is dropped or repeated
// reset: arst_n clears all stage valid bits and loads deviation limit 15, fail value 255
`timescale 1ns / 1ps

module oxygen_cell_vote
	import ocv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	ocv_stream_if.sink        sensor,
	ocv_stream_if.source      vote
);

	logic [CFG_W-1:0] max_dev_q;
	logic [CFG_W-1:0] fail_val_q;

	logic rdy1, rdy2, rdy3;

	// sort network
	ppo2_t      lo_c, mid_c, hi_c;
	cell_mask_t mlo_c, mmid_c, mhi_c;

	logic       v_s1;
	ocv_in_t    data_s1;
	ppo2_t      lo_s1, mid_s1, hi_s1;
	cell_mask_t mlo_s1, mhi_s1;
	logic       cal_s1;

	logic             keep_lo_c, keep_hi_c;
	logic [SUM_W-1:0] acc_c;
	logic [CNT_W-1:0] cnt_c;
	cell_mask_t       mask_c;

	logic             v_s2;
	ocv_in_t          data_s2;
	logic             cal_s2;
	logic [SUM_W-1:0] acc_s2;
	logic [CNT_W-1:0] cnt_s2;
	cell_mask_t       mask_s2;

	logic [SUM_W+DIV3_SHIFT-1:0] prod_c;
	logic [SUM_W-1:0]            quot_c;
	ocv_out_t                    res_c;

	logic     v_s3;
	ocv_out_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dev_q  <= DEV_LIMIT_RST;
			fail_val_q <= FAIL_VALUE_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_DEV_LIMIT:  max_dev_q  <= wr_data;
				REG_FAIL_VALUE: fail_val_q <= wr_data;
				default:        max_dev_q  <= max_dev_q;
			endcase
		end
	end

	assign rdy3 = !v_s3 || vote.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign sensor.ready = rdy1;

	always_comb begin
		ppo2_t      tv;
		cell_mask_t tm;
		tv     = '0;
		tm     = '0;
		lo_c   = sensor.data.cell1_ppo2;
		mid_c  = sensor.data.cell2_ppo2;
		hi_c   = sensor.data.cell3_ppo2;
		mlo_c  = CELL1_BIT;
		mmid_c = CELL2_BIT;
		mhi_c  = CELL3_BIT;
		if (lo_c > mid_c) begin
			tv = lo_c; lo_c = mid_c; mid_c = tv;
			tm = mlo_c; mlo_c = mmid_c; mmid_c = tm;
		end
		if (mid_c > hi_c) begin
			tv = mid_c; mid_c = hi_c; hi_c = tv;
			tm = mmid_c; mmid_c = mhi_c; mhi_c = tm;
		end
		if (lo_c > mid_c) begin
			tv = lo_c; lo_c = mid_c; mid_c = tv;
			tm = mlo_c; mlo_c = mmid_c; mmid_c = tm;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sensor.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && sensor.valid) begin
			data_s1 <= sensor.data;
			lo_s1   <= lo_c;
			mid_s1  <= mid_c;
			hi_s1   <= hi_c;
			mlo_s1  <= mlo_c;
			mhi_s1  <= mhi_c;
			cal_s1  <= |sensor.data.need_cal_flags;
		end
	end

	always_comb begin
		keep_lo_c = (mid_s1 - lo_s1) <= max_dev_q;
		keep_hi_c = (hi_s1 - mid_s1) <= max_dev_q;
		acc_c = SUM_W'(mid_s1)
			+ (keep_lo_c ? SUM_W'(lo_s1) : '0)
			+ (keep_hi_c ? SUM_W'(hi_s1) : '0);
		cnt_c = CNT_ONE + CNT_W'(keep_lo_c) + CNT_W'(keep_hi_c);
		mask_c = (keep_lo_c ? '0 : mlo_s1) | (keep_hi_c ? '0 : mhi_s1);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			data_s2 <= data_s1;
			cal_s2  <= cal_s1;
			acc_s2  <= acc_c;
			cnt_s2  <= cnt_c;
			mask_s2 <= mask_c;
		end
	end

	always_comb begin
		prod_c = SUM_W'(acc_s2) * (SUM_W + DIV3_SHIFT)'(DIV3_RECIP);
		unique case (cnt_s2)
			CNT_TWO:   quot_c = acc_s2 >> 1;
			CNT_THREE: quot_c = prod_c[SUM_W+DIV3_SHIFT-1:DIV3_SHIFT];
			default:   quot_c = acc_s2;
		endcase
		res_c.out_cell1_mv = data_s2.cell1_mv;
		res_c.out_cell2_mv = data_s2.cell2_mv;
		res_c.out_cell3_mv = data_s2.cell3_mv;
		if (cal_s2) begin
			res_c.out_cell1_ppo2 = fail_val_q;
			res_c.out_cell2_ppo2 = fail_val_q;
			res_c.out_cell3_ppo2 = fail_val_q;
			res_c.consensus_ppo2 = fail_val_q;
			res_c.voted_out_mask = '0;
		end else begin
			res_c.out_cell1_ppo2 = data_s2.cell1_ppo2;
			res_c.out_cell2_ppo2 = data_s2.cell2_ppo2;
			res_c.out_cell3_ppo2 = data_s2.cell3_ppo2;
			res_c.consensus_ppo2 = quot_c[PPO2_W-1:0];
			res_c.voted_out_mask = mask_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			res_s3 <= res_c;
		end
	end

	assign vote.valid = v_s3;
	assign vote.data  = res_s3;

endmodule

// ===== hdl/ocv_checker.sv =====
`timescale 1ns / 1ps
`include "oxygen_cell_vote_defines.svh"

module ocv_checker
	import ocv_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input ocv_out_t out_data
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	`OCV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
	`OCV_ASSERT_NOW(a_mask_outer, out_valid, $countones(out_data.voted_out_mask) <= 2, "more than two cells voted out")
	`OCV_ASSERT_NOW(a_voted_differs, out_valid && (out_data.voted_out_mask != '0), (!out_data.voted_out_mask[0] || (out_data.consensus_ppo2 != out_data.out_cell1_ppo2)) && (!out_data.voted_out_mask[1] || (out_data.consensus_ppo2 != out_data.out_cell2_ppo2)) && (!out_data.voted_out_mask[2] || (out_data.consensus_ppo2 != out_data.out_cell3_ppo2)), "voted-out cell equals consensus")
	`OCV_ASSERT_NEXT(a_latency, in_acc ##1 out_ready ##1 out_ready, out_valid, "result word late with free output")

endmodule

bind oxygen_cell_vote ocv_checker u_ocv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sensor.valid),
	.in_ready  (sensor.ready),
	.out_valid (vote.valid),
	.out_ready (vote.ready),
	.out_data  (vote.data)
);
